FILE: rtl/core/pia_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pia_pkg
// Shared types and codes of the positional insert/remove array: request
// modes, result status codes, and the command and status words that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package pia_pkg;

   // Request modes
   localparam logic [2:0] MODE_APPEND  = 3'd0;
   localparam logic [2:0] MODE_INSERT  = 3'd1;
   localparam logic [2:0] MODE_REMOVE  = 3'd2;
   localparam logic [2:0] MODE_GET     = 3'd3;
   localparam logic [2:0] MODE_REPLACE = 3'd4;
   localparam logic [2:0] MODE_CLEAR   = 3'd5;

   // Result status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_RANGE = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   // Memory read address source
   localparam logic [1:0] RD_POS    = 2'd0;
   localparam logic [1:0] RD_CUR_DN = 2'd1;
   localparam logic [1:0] RD_CUR_UP = 2'd2;

   // Memory write address and data source
   localparam logic [1:0] WR_FILL = 2'd0;
   localparam logic [1:0] WR_POS  = 2'd1;
   localparam logic [1:0] WR_CUR  = 2'd2;

   // Cursor operations
   localparam logic [2:0] CUR_HOLD      = 3'd0;
   localparam logic [2:0] CUR_LOAD_FILL = 3'd1;
   localparam logic [2:0] CUR_LOAD_POS  = 3'd2;
   localparam logic [2:0] CUR_INC       = 3'd3;
   localparam logic [2:0] CUR_DEC       = 3'd4;

   // Fill count operations
   localparam logic [1:0] FILL_HOLD  = 2'd0;
   localparam logic [1:0] FILL_INC   = 2'd1;
   localparam logic [1:0] FILL_DEC   = 2'd2;
   localparam logic [1:0] FILL_CLEAR = 2'd3;

   // Result index source
   localparam logic [1:0] IDX_ZERO = 2'd0;
   localparam logic [1:0] IDX_POS  = 2'd1;
   localparam logic [1:0] IDX_FILL = 2'd2;

   // Result word source
   localparam logic [1:0] RW_ZERO = 2'd0;
   localparam logic [1:0] RW_RD   = 2'd1;
   localparam logic [1:0] RW_OLD  = 2'd2;

   typedef struct packed {
      logic       latch_req;
      logic       rd_en;
      logic [1:0] rd_sel;
      logic       wr_en;
      logic [1:0] wr_sel;
      logic [2:0] cur_op;
      logic [1:0] fill_op;
      logic       old_load;
      logic       rsp_load;
      logic [1:0] rsp_status;
      logic [1:0] rsp_idx_sel;
      logic [1:0] rsp_word_sel;
   } cmd_type;

   typedef struct packed {
      logic [2:0] mode;
      logic       full;
      logic       pos_gt_fill;
      logic       pos_ge_fill;
      logic       cur_gt_pos;
      logic       cur_next_lt_fill;
   } stat_type;

endpackage

FILE: rtl/core/pia_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pia_dpath
// Datapath: request registers, entry memory, fill count, shift cursor and
// result registers. Acts only on commands from the controller.
// ----------------------------------------------------------------------------
module pia_dpath #(
   parameter int CAPACITY  = 64,
   parameter int WORD_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [2:0]        req_mode,
   input  logic [5:0]        req_position,
   input  logic [31:0]       req_word_in,
   input  pia_pkg::cmd_type  cmd,
   output pia_pkg::stat_type stat,
   output logic [1:0]        rsp_status,
   output logic [5:0]        rsp_index_out,
   output logic [31:0]       rsp_word_out,
   output logic [6:0]        rsp_entries
);

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > 7) ? CW : 7;
   localparam int XW   = (WORD_BITS > 32) ? WORD_BITS : 32;

   logic [WORD_BITS-1:0] slots_ff [CAPACITY];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic [WORD_BITS-1:0] old_ff;
   logic [WORD_BITS-1:0] word_ff;
   logic [2:0]           mode_ff;
   logic [5:0]           pos_ff;
   logic [CW-1:0]        fill_ff, fill_in;
   logic [CW-1:0]        cur_ff, cur_in;
   logic [1:0]           rsp_status_ff;
   logic [5:0]           rsp_index_ff;
   logic [31:0]          rsp_word_ff;
   logic [6:0]           rsp_entries_ff;

   logic [CMPW-1:0]      pos_x, fill_x, cur_x, fill_in_x;
   logic [CMPW:0]        cur_nx;
   logic [CW-1:0]        cur_dn;
   logic [AW-1:0]        pos_addr, rd_addr, wr_addr;
   logic [WORD_BITS-1:0] wr_data;
   logic [XW-1:0]        win_x, rd_x, old_x;

   assign pos_x     = CMPW'(pos_ff);
   assign fill_x    = CMPW'(fill_ff);
   assign cur_x     = CMPW'(cur_ff);
   assign fill_in_x = CMPW'(fill_in);
   assign cur_nx    = {1'b0, cur_x} + {{CMPW{1'b0}}, 1'b1};
   assign cur_dn    = cur_ff - {{(CW-1){1'b0}}, 1'b1};
   assign pos_addr  = pos_x[AW-1:0];
   assign win_x     = XW'(req_word_in);
   assign rd_x      = XW'(rd_data_ff);
   assign old_x     = XW'(old_ff);

   assign stat.mode             = mode_ff;
   assign stat.full             = (fill_ff == CW'(CAPACITY));
   assign stat.pos_gt_fill      = (pos_x > fill_x);
   assign stat.pos_ge_fill      = (pos_x >= fill_x);
   assign stat.cur_gt_pos       = (cur_x > pos_x);
   assign stat.cur_next_lt_fill = (cur_nx < {1'b0, fill_x});

   always_comb begin
      case (cmd.rd_sel)
         pia_pkg::RD_CUR_DN: rd_addr = cur_dn[AW-1:0];
         pia_pkg::RD_CUR_UP: rd_addr = cur_nx[AW-1:0];
         default:            rd_addr = pos_addr;
      endcase
   end

   always_comb begin
      case (cmd.wr_sel)
         pia_pkg::WR_FILL: begin
            wr_addr = fill_ff[AW-1:0];
            wr_data = word_ff;
         end
         pia_pkg::WR_CUR: begin
            wr_addr = cur_ff[AW-1:0];
            wr_data = rd_data_ff;
         end
         default: begin
            wr_addr = pos_addr;
            wr_data = word_ff;
         end
      endcase
   end

   always_comb begin
      case (cmd.fill_op)
         pia_pkg::FILL_INC:   fill_in = fill_ff + {{(CW-1){1'b0}}, 1'b1};
         pia_pkg::FILL_DEC:   fill_in = fill_ff - {{(CW-1){1'b0}}, 1'b1};
         pia_pkg::FILL_CLEAR: fill_in = '0;
         default:             fill_in = fill_ff;
      endcase
   end

   always_comb begin
      case (cmd.cur_op)
         pia_pkg::CUR_LOAD_FILL: cur_in = fill_ff;
         pia_pkg::CUR_LOAD_POS:  cur_in = pos_x[CW-1:0];
         pia_pkg::CUR_INC:       cur_in = cur_nx[CW-1:0];
         pia_pkg::CUR_DEC:       cur_in = cur_dn;
         default:                cur_in = cur_ff;
      endcase
   end

   // Entry memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         slots_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= slots_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (cmd.latch_req) begin
         mode_ff <= req_mode;
         pos_ff  <= req_position;
         word_ff <= win_x[WORD_BITS-1:0];
      end
      if (cmd.old_load) begin
         old_ff <= rd_data_ff;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff  <= cmd.rsp_status;
         rsp_entries_ff <= fill_in_x[6:0];
         case (cmd.rsp_idx_sel)
            pia_pkg::IDX_POS:  rsp_index_ff <= pos_ff;
            pia_pkg::IDX_FILL: rsp_index_ff <= fill_x[5:0];
            default:           rsp_index_ff <= '0;
         endcase
         case (cmd.rsp_word_sel)
            pia_pkg::RW_RD:  rsp_word_ff <= rd_x[31:0];
            pia_pkg::RW_OLD: rsp_word_ff <= old_x[31:0];
            default:         rsp_word_ff <= '0;
         endcase
      end
   end

   assign rsp_status    = rsp_status_ff;
   assign rsp_index_out = rsp_index_ff;
   assign rsp_word_out  = rsp_word_ff;
   assign rsp_entries   = rsp_entries_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(CAPACITY))
      else $error("fill count above capacity");

   a_no_grow_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.fill_op == pia_pkg::FILL_INC) |-> !stat.full)
      else $error("fill count grows past a full array");

   a_wr_addr_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> (CMPW'(wr_addr) < CMPW'(CAPACITY)))
      else $error("memory write beyond capacity");

endmodule

FILE: rtl/core/pia_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pia_ctrl
// Controller: decodes the latched request, runs the one-entry-at-a-time
// shift for insert and remove, and issues the result strobe.
// ----------------------------------------------------------------------------
module pia_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  pia_pkg::stat_type stat,
   output pia_pkg::cmd_type  cmd,
   output logic              busy,
   output logic              rsp_valid
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DECODE   = 3'd1;
   localparam logic [2:0] S_INS_LOOP = 3'd2;
   localparam logic [2:0] S_INS_WR   = 3'd3;
   localparam logic [2:0] S_ACCESS   = 3'd4;
   localparam logic [2:0] S_REM_LOOP = 3'd5;
   localparam logic [2:0] S_REM_WR   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff;

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch_req = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in     = S_IDLE;
            cmd.rsp_load = 1'b1;
            case (stat.mode)
               pia_pkg::MODE_APPEND: begin
                  if (stat.full) begin
                     cmd.rsp_status = pia_pkg::STAT_FULL;
                  end else begin
                     cmd.wr_en       = 1'b1;
                     cmd.wr_sel      = pia_pkg::WR_FILL;
                     cmd.fill_op     = pia_pkg::FILL_INC;
                     cmd.rsp_idx_sel = pia_pkg::IDX_FILL;
                  end
               end
               pia_pkg::MODE_INSERT: begin
                  if (stat.pos_gt_fill) begin
                     cmd.rsp_status = pia_pkg::STAT_RANGE;
                  end else if (stat.full) begin
                     cmd.rsp_status = pia_pkg::STAT_FULL;
                  end else begin
                     cmd.rsp_load = 1'b0;
                     cmd.cur_op   = pia_pkg::CUR_LOAD_FILL;
                     state_in     = S_INS_LOOP;
                  end
               end
               pia_pkg::MODE_REMOVE, pia_pkg::MODE_GET, pia_pkg::MODE_REPLACE: begin
                  if (stat.pos_ge_fill) begin
                     cmd.rsp_status = pia_pkg::STAT_RANGE;
                  end else begin
                     cmd.rsp_load = 1'b0;
                     cmd.rd_en    = 1'b1;
                     cmd.rd_sel   = pia_pkg::RD_POS;
                     state_in     = S_ACCESS;
                  end
               end
               pia_pkg::MODE_CLEAR: begin
                  cmd.fill_op = pia_pkg::FILL_CLEAR;
               end
               default: begin
               end
            endcase
         end
         // Insert moves entries up from the top, one read and one write each.
         S_INS_LOOP: begin
            if (stat.cur_gt_pos) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = pia_pkg::RD_CUR_DN;
               state_in   = S_INS_WR;
            end else begin
               cmd.wr_en       = 1'b1;
               cmd.wr_sel      = pia_pkg::WR_POS;
               cmd.fill_op     = pia_pkg::FILL_INC;
               cmd.rsp_load    = 1'b1;
               cmd.rsp_idx_sel = pia_pkg::IDX_POS;
               state_in        = S_IDLE;
            end
         end
         S_INS_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = pia_pkg::WR_CUR;
            cmd.cur_op = pia_pkg::CUR_DEC;
            state_in   = S_INS_LOOP;
         end
         // The addressed entry has been read; its word is now available.
         S_ACCESS: begin
            if (stat.mode == pia_pkg::MODE_REMOVE) begin
               cmd.old_load = 1'b1;
               cmd.cur_op   = pia_pkg::CUR_LOAD_POS;
               state_in     = S_REM_LOOP;
            end else begin
               cmd.wr_en        = (stat.mode == pia_pkg::MODE_REPLACE);
               cmd.wr_sel       = pia_pkg::WR_POS;
               cmd.rsp_load     = 1'b1;
               cmd.rsp_idx_sel  = pia_pkg::IDX_POS;
               cmd.rsp_word_sel = pia_pkg::RW_RD;
               state_in         = S_IDLE;
            end
         end
         S_REM_LOOP: begin
            if (stat.cur_next_lt_fill) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = pia_pkg::RD_CUR_UP;
               state_in   = S_REM_WR;
            end else begin
               cmd.fill_op      = pia_pkg::FILL_DEC;
               cmd.rsp_load     = 1'b1;
               cmd.rsp_idx_sel  = pia_pkg::IDX_POS;
               cmd.rsp_word_sel = pia_pkg::RW_OLD;
               state_in         = S_IDLE;
            end
         end
         S_REM_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = pia_pkg::WR_CUR;
            cmd.cur_op = pia_pkg::CUR_INC;
            state_in   = S_REM_LOOP;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= cmd.rsp_load;
      end
   end

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not make the block busy");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == S_IDLE || state_ff == S_DECODE))
      else $error("result strobe while an operation is still running");

endmodule

FILE: rtl/core/positional_insert_remove_array.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_insert_remove_array
// Ordered array of data words with append, insert, remove, get, replace and
// clear requests; one result word per request.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                                           Handshake
//   request   req_mode, req_position, req_word_in             start && !busy
//   result    rsp_status, rsp_index_out, rsp_word_out,        rsp_valid, one
//             rsp_entries                                     cycle, no stall
//
// A result strobes once the decode state has run for append, clear and every
// rejected request, and once the decode and access states have run for get
// and replace. Insert and remove move one entry at a time through the entry
// memory (a registered read, then a write). busy drops in the cycle the
// strobe is shown, so the next word can be accepted then. Reset clears the
// entry count, the controller state and the result strobe; the entry memory
// holds no reset value and needs no clearing.
// ----------------------------------------------------------------------------
module positional_insert_remove_array #(
   parameter int CAPACITY  = 64,
   parameter int WORD_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_mode,
   input  logic [5:0]  req_position,
   input  logic [31:0] req_word_in,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [5:0]  rsp_index_out,
   output logic [31:0] rsp_word_out,
   output logic [6:0]  rsp_entries
);

   pia_pkg::cmd_type  cmd;
   pia_pkg::stat_type stat;

   pia_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   pia_dpath #(
      .CAPACITY  (CAPACITY),
      .WORD_BITS (WORD_BITS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .req_mode      (req_mode),
      .req_position  (req_position),
      .req_word_in   (req_word_in),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_status    (rsp_status),
      .rsp_index_out (rsp_index_out),
      .rsp_word_out  (rsp_word_out),
      .rsp_entries   (rsp_entries)
   );

endmodule
